[src/pcm_agc_pkg.sv]
package pcm_agc_pkg;

   // Controller states
   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_CLIP,
      ST_JUDGE,
      ST_DIV,
      ST_STEP,
      ST_APPLY,
      ST_SETTLE,
      ST_PLAY,
      ST_PARK_NOTE,
      ST_PROBE,
      ST_RESUME_NOTE
   } agc_state_type;

   localparam int DIV_W = 35;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_result_type;

   typedef struct packed {
      logic valid;
      logic last;
   } duty_tag_type;

   // Register map (word index from paddr[2])
   localparam logic REG_CARRIER = 1'b0;
   localparam logic REG_SILENT  = 1'b1;

   localparam logic [15:0] CARRIER_RESET = 16'd16000;
   localparam logic [7:0]  SILENT_RESET  = 8'd4;

   // Gain in Q5.19
   localparam logic [23:0] GAIN_ONE   = 24'h080000;
   localparam logic [23:0] GAIN_RESET = 24'h200000;
   localparam logic [23:0] GAIN_CEIL  = 24'hA00000;
   localparam logic [23:0] GAIN_MAX   = 24'hFFFFFF;

   localparam logic [DIV_W-1:0] FULL_SCALE = 35'h4_0000_0000;
   localparam logic [DIV_W-1:0] TARGET     = 35'd14602888806;
   localparam logic [15:0]      PEAK_THRESHOLD = 16'd32;

   localparam logic [22:0] ATTACK_COEF  = 23'd4294967;
   localparam logic [22:0] RELEASE_COEF = 23'd429497;

   // ceil(2^26 / 25): exact floor division by 25 for values below 2^21
   localparam logic [21:0] RECIP_25 = 22'd2684355;

endpackage

[src/pcm_agc_ram.sv]
module pcm_agc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/pcm_agc_div.sv]
module pcm_agc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pcm_agc_pkg::DIV_W-1:0] dividend,
   input  logic [15:0]                   divisor,
   output pcm_agc_pkg::div_result_type   result
);

   localparam int N = pcm_agc_pkg::DIV_W;
   localparam int CW = $clog2(N);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0]   rem_ff, rem_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [15:0]   dvs_ff, dvs_in;
   logic [16:0]   shifted;
   logic [16:0]   trial;

   // One quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[N-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

[src/pcm_agc_duty.sv]
module pcm_agc_duty (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  pcm_agc_pkg::duty_tag_type in_tag,
   input  logic signed [15:0]        sample,
   input  logic [23:0]               gain,
   input  logic [15:0]               carrier,
   output pcm_agc_pkg::duty_tag_type out_tag,
   output logic [15:0]               duty,
   output logic                      busy
);

   localparam logic signed [40:0] LIM = 41'sh4_0000_0000;

   pcm_agc_pkg::duty_tag_type t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [40:0] x_ff;
   logic [41:0]        u_ff;
   logic [36:0]        pl_ff, ph_ff;
   logic [20:0]        v_ff;

   logic signed [40:0] x_cl;
   logic [35:0]        n_val;
   logic [41:0]        u_in;
   logic [57:0]        p_sum;
   logic [41:0]        q_prod;

   // Clamp to full scale, offset to unsigned, form 2^34 + 99 n
   always_comb begin
      x_cl = x_ff;
      if (x_ff > LIM) begin
         x_cl = LIM;
      end else if (x_ff < -LIM) begin
         x_cl = -LIM;
      end
      n_val = 36'(x_cl + LIM);
      u_in  = 42'h4_0000_0000 + 42'(n_val) * 42'd99;
      p_sum = {ph_ff, 21'b0} + 58'(pl_ff);
   end

   // Pipeline stages, all held together on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
      end else if (adv) begin
         t1_ff <= in_tag;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
      end
      if (adv) begin
         x_ff  <= sample * $signed({1'b0, gain});
         u_ff  <= u_in;
         pl_ff <= carrier * u_ff[20:0];
         ph_ff <= carrier * u_ff[41:21];
         v_ff  <= p_sum[57:37];
      end
   end

   // Divide by 25 through the reciprocal
   assign q_prod  = v_ff * pcm_agc_pkg::RECIP_25;
   assign duty    = q_prod[41:26];
   assign out_tag = t4_ff;
   assign busy    = t1_ff.valid | t2_ff.valid | t3_ff.valid | t4_ff.valid;

endmodule

[src/pcm_agc_to_pwm_duty_unit.sv]
// Automatic gain control from signed 16-bit PCM (32768 = 1.0) to PWM duty counts.
// Samples are taken one per cycle while collecting, into a buffer RAM of BUFFER_FRAMES
// entries; nothing comes out until the buffer is full. A full buffer then costs a gain
// update, using the bit-serial divider (2^34 or 0.85*2^34 over the peak), followed by
// one result per cycle while the receiver is ready, read out of the buffer RAM through
// the duty pipeline. A park or resume gives a single result with duty 0. While parked
// the block takes probe windows of PROBE_LEN samples and only gives a result when a
// window held a nonzero sample. Registers: carrier period at 0x0,
// silent_buffers_to_park at 0x4; write them only while idle.
module pcm_agc_to_pwm_duty_unit #(
   parameter int BUFFER_FRAMES = 64,
   parameter int PROBE_LEN     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] duty
   output logic        rsp_tuser,   // [0] output_on
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MAXF   = (BUFFER_FRAMES > PROBE_LEN) ? BUFFER_FRAMES : PROBE_LEN;
   localparam int FILL_W = $clog2(MAXF + 1);
   localparam int AW     = (BUFFER_FRAMES > 1) ? $clog2(BUFFER_FRAMES) : 1;

   pcm_agc_pkg::agc_state_type state_ff, state_in;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [15:0]       peak_ff, peak_in;
   logic [23:0]       gain_ff, gain_in;
   logic [7:0]        silent_ff, silent_in;
   logic              seen_ff, seen_in;
   logic [39:0]       prod_ff, prod_in;
   logic              clip_mode_ff, clip_mode_in;
   logic [23:0]       mag_ff, mag_in;
   logic              attack_ff, attack_in;
   logic [46:0]       stepprod_ff, stepprod_in;
   logic [15:0]       carrier_ff;
   logic [7:0]        thresh_ff;
   logic              iss_ff, iss_last_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_duty_ff;
   logic              rsp_on_ff, rsp_last_ff;

   logic              adv, accept, issue, note_fire, div_start, pipe_busy, csr_write;
   logic              clip, tracking, buffer_done, probe_done, seen_nx;
   logic [FILL_W-1:0] fill_nx;
   logic [15:0]       mag_s;
   logic [7:0]        silent_nx;
   logic [pcm_agc_pkg::DIV_W-1:0] dividend;
   logic [23:0]       desired;
   logic [47:0]       rnd;
   logic [15:0]       step;
   logic [24:0]       gsum;
   logic [15:0]       rd_data;

   pcm_agc_pkg::div_result_type div_res;
   pcm_agc_pkg::duty_tag_type   pipe_in_tag, pipe_out_tag;
   logic [15:0]                 pipe_duty;
   logic                        pipe_is_busy;

   // Shared conditions
   assign adv         = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign mag_s       = req_tdata[15] ? 16'(-req_tdata) : req_tdata;
   assign fill_nx     = fill_ff + 1'b1;
   assign buffer_done = fill_nx == FILL_W'(BUFFER_FRAMES);
   assign probe_done  = fill_nx == FILL_W'(PROBE_LEN);
   assign seen_nx     = seen_ff || (req_tdata != 16'd0);
   assign clip        = prod_ff > 40'(pcm_agc_pkg::FULL_SCALE);
   assign tracking    = peak_ff > pcm_agc_pkg::PEAK_THRESHOLD;
   assign silent_nx   = (peak_ff != 16'd0) ? 8'd0 :
                        ((silent_ff == 8'hFF) ? silent_ff : silent_ff + 8'd1);
   assign pipe_busy   = iss_ff || pipe_is_busy;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcm_agc_pkg::ST_COLLECT: begin
            if (accept && buffer_done) begin
               state_in = pcm_agc_pkg::ST_CLIP;
            end
         end
         pcm_agc_pkg::ST_CLIP: begin
            if (!pipe_busy) begin
               state_in = pcm_agc_pkg::ST_JUDGE;
            end
         end
         pcm_agc_pkg::ST_JUDGE: begin
            state_in = (clip || tracking) ? pcm_agc_pkg::ST_DIV : pcm_agc_pkg::ST_SETTLE;
         end
         pcm_agc_pkg::ST_DIV: begin
            if (div_res.done) begin
               state_in = clip_mode_ff ? pcm_agc_pkg::ST_SETTLE : pcm_agc_pkg::ST_STEP;
            end
         end
         pcm_agc_pkg::ST_STEP: state_in = pcm_agc_pkg::ST_APPLY;
         pcm_agc_pkg::ST_APPLY: state_in = pcm_agc_pkg::ST_SETTLE;
         pcm_agc_pkg::ST_SETTLE: begin
            state_in = (silent_nx >= thresh_ff) ? pcm_agc_pkg::ST_PARK_NOTE
                                                : pcm_agc_pkg::ST_PLAY;
         end
         pcm_agc_pkg::ST_PLAY: begin
            if (adv && rd_cnt_ff == FILL_W'(BUFFER_FRAMES - 1)) begin
               state_in = pcm_agc_pkg::ST_COLLECT;
            end
         end
         pcm_agc_pkg::ST_PARK_NOTE: begin
            if (adv) begin
               state_in = pcm_agc_pkg::ST_PROBE;
            end
         end
         pcm_agc_pkg::ST_PROBE: begin
            if (accept && probe_done && seen_nx) begin
               state_in = pcm_agc_pkg::ST_RESUME_NOTE;
            end
         end
         pcm_agc_pkg::ST_RESUME_NOTE: begin
            if (adv) begin
               state_in = pcm_agc_pkg::ST_COLLECT;
            end
         end
         default: state_in = pcm_agc_pkg::ST_COLLECT;
      endcase
   end

   // Control outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      note_fire  = 1'b0;
      div_start  = 1'b0;
      dividend   = clip ? pcm_agc_pkg::FULL_SCALE : pcm_agc_pkg::TARGET;
      unique case (state_ff)
         pcm_agc_pkg::ST_COLLECT,
         pcm_agc_pkg::ST_PROBE:       req_tready = 1'b1;
         pcm_agc_pkg::ST_JUDGE:       div_start  = clip || tracking;
         pcm_agc_pkg::ST_PLAY:        issue      = adv;
         pcm_agc_pkg::ST_PARK_NOTE,
         pcm_agc_pkg::ST_RESUME_NOTE: note_fire  = adv;
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      fill_in      = fill_ff;
      rd_cnt_in    = rd_cnt_ff;
      peak_in      = peak_ff;
      gain_in      = gain_ff;
      silent_in    = silent_ff;
      seen_in      = seen_ff;
      prod_in      = prod_ff;
      clip_mode_in = clip_mode_ff;
      mag_in       = mag_ff;
      attack_in    = attack_ff;
      stepprod_in  = stepprod_ff;
      desired      = (div_res.quotient > 35'(pcm_agc_pkg::GAIN_CEIL)) ?
                     pcm_agc_pkg::GAIN_CEIL : div_res.quotient[23:0];
      rnd          = {1'b0, stepprod_ff} + 48'h0000_8000_0000;
      step         = rnd[47:32];
      gsum         = {1'b0, gain_ff} + 25'(step);
      unique case (state_ff)
         pcm_agc_pkg::ST_COLLECT: begin
            if (accept) begin
               if (mag_s > peak_ff) begin
                  peak_in = mag_s;
               end
               fill_in = buffer_done ? '0 : fill_nx;
            end
         end
         pcm_agc_pkg::ST_CLIP: prod_in = peak_ff * gain_ff;
         pcm_agc_pkg::ST_JUDGE: clip_mode_in = clip;
         pcm_agc_pkg::ST_DIV: begin
            if (div_res.done) begin
               if (clip_mode_ff) begin
                  if (div_res.quotient < 35'(pcm_agc_pkg::GAIN_ONE)) begin
                     gain_in = pcm_agc_pkg::GAIN_ONE;
                  end else if (div_res.quotient > 35'(pcm_agc_pkg::GAIN_MAX)) begin
                     gain_in = pcm_agc_pkg::GAIN_MAX;
                  end else begin
                     gain_in = div_res.quotient[23:0];
                  end
               end else begin
                  attack_in = desired < gain_ff;
                  mag_in    = (desired < gain_ff) ? gain_ff - desired : desired - gain_ff;
               end
            end
         end
         pcm_agc_pkg::ST_STEP: begin
            stepprod_in = mag_ff * (attack_ff ? pcm_agc_pkg::ATTACK_COEF
                                              : pcm_agc_pkg::RELEASE_COEF);
         end
         pcm_agc_pkg::ST_APPLY: begin
            if (attack_ff) begin
               gain_in = (24'(step) > gain_ff) ? 24'd0 : gain_ff - 24'(step);
            end else begin
               gain_in = gsum[24] ? pcm_agc_pkg::GAIN_MAX : gsum[23:0];
            end
         end
         pcm_agc_pkg::ST_SETTLE: begin
            silent_in = silent_nx;
            peak_in   = '0;
            rd_cnt_in = '0;
            seen_in   = 1'b0;
         end
         pcm_agc_pkg::ST_PLAY: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end
         pcm_agc_pkg::ST_PROBE: begin
            if (accept) begin
               if (probe_done) begin
                  fill_in = '0;
                  seen_in = 1'b0;
                  if (seen_nx) begin
                     silent_in = '0;
                     peak_in   = '0;
                  end
               end else begin
                  fill_in = fill_nx;
                  seen_in = seen_nx;
               end
            end
         end
         default: ;
      endcase
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcm_agc_pkg::ST_COLLECT;
         fill_ff      <= '0;
         peak_ff      <= '0;
         gain_ff      <= pcm_agc_pkg::GAIN_RESET;
         silent_ff    <= '0;
         seen_ff      <= 1'b0;
         carrier_ff   <= pcm_agc_pkg::CARRIER_RESET;
         thresh_ff    <= pcm_agc_pkg::SILENT_RESET;
         iss_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         peak_ff   <= peak_in;
         gain_ff   <= gain_in;
         silent_ff <= silent_in;
         seen_ff   <= seen_in;
         if (csr_write) begin
            if (csr_paddr[2] == pcm_agc_pkg::REG_CARRIER) begin
               carrier_ff <= csr_pwdata[15:0];
            end else begin
               thresh_ff <= csr_pwdata[7:0];
            end
         end
         if (adv) begin
            iss_ff       <= issue;
            rsp_valid_ff <= pipe_out_tag.valid || note_fire;
         end
      end
      rd_cnt_ff    <= rd_cnt_in;
      prod_ff      <= prod_in;
      clip_mode_ff <= clip_mode_in;
      mag_ff       <= mag_in;
      attack_ff    <= attack_in;
      stepprod_ff  <= stepprod_in;
      if (adv) begin
         iss_last_ff <= rd_cnt_ff == FILL_W'(BUFFER_FRAMES - 1);
         rsp_duty_ff <= note_fire ? 16'd0 : pipe_duty;
         rsp_on_ff   <= note_fire ? (state_ff == pcm_agc_pkg::ST_RESUME_NOTE) : 1'b1;
         rsp_last_ff <= note_fire ? 1'b1 : pipe_out_tag.last;
      end
   end

   // Sample buffer
   pcm_agc_ram #(
      .WIDTH(16),
      .DEPTH(BUFFER_FRAMES)
   ) u_buffer (
      .clock(clock),
      .we   (accept && state_ff == pcm_agc_pkg::ST_COLLECT),
      .waddr(fill_ff[AW-1:0]),
      .wdata(req_tdata),
      .re   (adv),
      .raddr(rd_cnt_ff[AW-1:0]),
      .rdata(rd_data)
   );

   pcm_agc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(dividend),
      .divisor (peak_ff),
      .result  (div_res)
   );

   assign pipe_in_tag.valid = iss_ff;
   assign pipe_in_tag.last  = iss_last_ff;

   pcm_agc_duty u_duty (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .in_tag (pipe_in_tag),
      .sample ($signed(rd_data)),
      .gain   (gain_ff),
      .carrier(carrier_ff),
      .out_tag(pipe_out_tag),
      .duty   (pipe_duty),
      .busy   (pipe_is_busy)
   );

   // Ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_duty_ff;
   assign rsp_tuser  = rsp_on_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pcm_agc_pkg::REG_CARRIER) ? {16'd0, carrier_ff}
                                                                  : {24'd0, thresh_ff};

   // Checks
   a_duty_below_carrier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_on_ff && !rsp_last_ff |-> rsp_duty_ff <= carrier_ff)
      else $error("duty above carrier period");

   a_park_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_on_ff |-> rsp_duty_ff == 16'd0 && rsp_last_ff)
      else $error("park result malformed");

   a_gain_stable_in_play: assert property (@(posedge clock) disable iff (reset)
      pipe_busy |=> $stable(gain_ff))
      else $error("gain changed while samples in flight");

   a_no_input_while_playing: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcm_agc_pkg::ST_PLAY |-> !req_tready)
      else $error("input taken during readout");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAMES      = 64;
   localparam int PROBE       = 16;
   localparam int DRAIN_WAIT  = 250;
   localparam int WATCH_LIMIT = 20000;
   localparam longint unsigned FULL_Q34 = 64'd17179869184;
   localparam longint unsigned TARGET_Q34 = 64'd14602888806;

   typedef struct packed {
      logic [15:0] duty;
      logic        on;
      logic        last;
   } pwm_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [15:0] pcm_buf [FRAMES];
   int unsigned frame_fill;
   int unsigned buf_peak;
   longint unsigned model_gain;
   int unsigned zero_run;
   bit          is_parked;
   bit          probe_hit;
   logic [15:0] carrier_q;
   logic [7:0]  park_after_q;

   pwm_result_type duty_expect_q[$];
   int error_count;
   int samples_sent;
   int results_seen;
   int park_count;
   int resume_count;
   int burst_left;
   int watch_count;
   bit hold_start;
   int hold_left;
   int stall_mode;
   int stall_phase;

   pcm_agc_to_pwm_duty_unit u_top (.*);

   always #6 clock = ~clock;

   // gain update on a full buffer
   task automatic agc_update_gain(input longint unsigned pk);
      longint unsigned desired, coef, mag, step;
      if (pk * model_gain > FULL_Q34) begin
         desired = FULL_Q34 / pk;
         if (desired < 64'(pcm_agc_pkg::GAIN_ONE)) desired = 64'(pcm_agc_pkg::GAIN_ONE);
         if (desired > 64'(pcm_agc_pkg::GAIN_MAX)) desired = 64'(pcm_agc_pkg::GAIN_MAX);
         model_gain = desired;
      end else if (pk > 32) begin
         desired = TARGET_Q34 / pk;
         if (desired > 64'(pcm_agc_pkg::GAIN_CEIL)) desired = 64'(pcm_agc_pkg::GAIN_CEIL);
         coef = (desired < model_gain) ? 64'd4294967 : 64'd429497;
         mag  = (desired < model_gain) ? model_gain - desired : desired - model_gain;
         step = (mag * coef + 64'd2147483648) >> 32;
         if (desired < model_gain)
            model_gain = (step > model_gain) ? 0 : model_gain - step;
         else
            model_gain = model_gain + step;
         if (model_gain > 64'(pcm_agc_pkg::GAIN_MAX)) model_gain = 64'(pcm_agc_pkg::GAIN_MAX);
      end
   endtask

   function automatic logic [15:0] duty_for(input logic signed [15:0] s);
      longint x;
      longint unsigned n, num;
      x = longint'(s) * longint'(model_gain);
      if (x > longint'(FULL_Q34)) x = longint'(FULL_Q34);
      if (x < -longint'(FULL_Q34)) x = -longint'(FULL_Q34);
      n = longint'(x) + FULL_Q34;
      num = 64'(carrier_q) * (2 * FULL_Q34 + 198 * n);
      return 16'(num / (400 * FULL_Q34));
   endfunction

   // work out the results one accepted sample causes
   task automatic agc_model_sample(input logic signed [15:0] s);
      int unsigned m;
      m = (s < 0) ? -int'(s) : int'(s);
      if (is_parked) begin
         if (s != 0) probe_hit = 1;
         frame_fill++;
         if (frame_fill < PROBE) return;
         frame_fill = 0;
         if (!probe_hit) return;
         probe_hit = 0;
         is_parked = 0;
         zero_run = 0;
         buf_peak = 0;
         resume_count++;
         duty_expect_q.push_back('{16'd0, 1'b1, 1'b1});
         return;
      end
      pcm_buf[frame_fill] = s;
      if (m > buf_peak) buf_peak = m;
      frame_fill++;
      if (frame_fill < FRAMES) return;
      frame_fill = 0;
      agc_update_gain(buf_peak);
      if (buf_peak == 0) begin
         if (zero_run < 255) zero_run++;
      end else begin
         zero_run = 0;
      end
      buf_peak = 0;
      if (zero_run >= park_after_q) begin
         is_parked = 1;
         probe_hit = 0;
         park_count++;
         duty_expect_q.push_back('{16'd0, 1'b0, 1'b1});
         return;
      end
      for (int k = 0; k < FRAMES; k++)
         duty_expect_q.push_back('{duty_for(pcm_buf[k]), 1'b1, 1'b1 * (k == FRAMES - 1)});
   endtask

   // offer one sample, in bursts with random gaps
   task automatic send_sample(input logic signed [15:0] s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = s;
      do @(posedge clock); while (!req_tready);
      agc_model_sample(s);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_tvalid = 1'b0;
   endtask

   // write a register, then read it back
   task automatic csr_write(input logic addr_bit, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = {addr_bit, 2'b00}; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (addr_bit == pcm_agc_pkg::REG_CARRIER) carrier_q = value[15:0];
      else park_after_q = value[7:0];
      @(negedge clock);
      csr_pwrite = 1'b0; csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata != ((addr_bit == pcm_agc_pkg::REG_CARRIER) ? {16'd0, carrier_q}
                                                                : {24'd0, park_after_q}))
      begin
         error_count++;
         if (error_count <= 10)
            $display("register readback at %0d: expected %0h, got %0h",
                     csr_paddr, value, csr_prdata);
      end
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0;
   endtask

   // wait for every expected result, then let the block go quiet
   task automatic settle();
      stop_sending();
      while (duty_expect_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic send_buffer(input int unsigned amp);
      for (int i = 0; i < FRAMES; i++)
         send_sample(16'($signed($urandom_range(0, 2 * amp)) - $signed(amp)));
   endtask

   task automatic send_constant(input logic [15:0] v, input int count);
      for (int i = 0; i < count; i++) send_sample(v);
   endtask

   // extremes of the sample field, clip from the reset gain
   task automatic test_extremes();
      logic [15:0] edge_vals [8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                                      16'hFFFF, 16'h0020, 16'h0021, 16'hFFDF};
      for (int i = 0; i < FRAMES; i++) send_sample(edge_vals[i % 8]);
      settle();
   endtask

   // a peak just under full scale at unity gain pulls the gain down
   task automatic test_gain_tracking();
      send_buffer(30000);
      settle();
   endtask

   // silent buffer parks, a quiet probe window stays parked, a nonzero probe resumes
   task automatic test_park_resume();
      csr_write(pcm_agc_pkg::REG_SILENT, 32'd1);
      send_constant(16'd0, FRAMES);
      send_constant(16'd0, PROBE);
      send_constant(16'd0, PROBE - 1);
      send_sample(16'h8000);
      settle();
      csr_write(pcm_agc_pkg::REG_SILENT, 32'd4);
   endtask

   // long receiver hold-off at the widest carrier while samples keep coming
   task automatic test_backpressure();
      csr_write(pcm_agc_pkg::REG_CARRIER, 32'd65535);
      hold_start = 1'b1;
      send_buffer(1000);
      for (int i = 0; i < PROBE; i++) send_sample(16'($urandom));
      settle();
   endtask

   // receiver: stall pattern, or a long hold-off on request
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_start) begin
         hold_start <= 1'b0;
         hold_left  <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= (stall_phase % 4 != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      pwm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (duty_expect_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: duty %0d on %0b last %0b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = duty_expect_q.pop_front();
            if (want.duty !== rsp_tdata || want.on !== rsp_tuser || want.last !== rsp_tlast)
            begin
               error_count++;
               if (error_count <= 10)
                  $display("result %0d: expected duty %0d on %0b last %0b, got %0d %0b %0b",
                           results_seen, want.duty, want.on, want.last,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel || reset)
         watch_count <= 0;
      else if (watch_count >= WATCH_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else
         watch_count <= watch_count + 1;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; rsp_tready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      hold_start = 1'b0; hold_left = 0; stall_mode = 0; stall_phase = 0;
      watch_count = 0; burst_left = 0; error_count = 0;
      samples_sent = 0; results_seen = 0; park_count = 0; resume_count = 0;
      frame_fill = 0; buf_peak = 0; model_gain = 64'(pcm_agc_pkg::GAIN_RESET); zero_run = 0;
      is_parked = 0; probe_hit = 0;
      carrier_q = pcm_agc_pkg::CARRIER_RESET; park_after_q = pcm_agc_pkg::SILENT_RESET;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_gain_tracking();
      test_park_resume();
      test_backpressure();

      stop_sending();
      while (duty_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("covered %0d samples, %0d duty results, %0d parks, %0d resumes",
               samples_sent, results_seen, park_count, resume_count);
      $display("clip, attack and release gain steps, park and probe resume, widest carrier "
               , "under a long output stall");
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[pcm_agc_to_pwm_duty_unit.f]
src/pcm_agc_pkg.sv
src/pcm_agc_ram.sv
src/pcm_agc_div.sv
src/pcm_agc_duty.sv
src/pcm_agc_to_pwm_duty_unit.sv
verif/tb_top.sv
